// ===== rtl/braitenberg_wheel_speed_assert.svh =====
// Assertion macros used by the wheel speed top module.
`ifndef BRAITENBERG_WHEEL_SPEED_ASSERT_SVH
`define BRAITENBERG_WHEEL_SPEED_ASSERT_SVH

// Same-cycle implication, clocked on clk and disabled while rst is high.
`define BWS_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk and disabled while rst is high.
`define BWS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/bws_pkg.sv =====
// Shared constants and coefficient tables of the wheel speed block.
package bws_pkg;

  localparam int SENSOR_COUNT_DEF = 8;
  localparam int READING_BITS_DEF = 12;
  localparam int MAX_SENSORS      = 16;

  // Coefficient and limit widths.
  localparam int COEF_W  = 6;
  localparam int LIMIT_W = 10;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 10'd400;

  // Result field widths.
  localparam int SPEED_W      = 11;
  localparam int PEAK_W       = 12;
  localparam int RSUM_OUT_W   = 15;
  localparam int OUT_FIELDS_W = 2 * SPEED_W + PEAK_W + RSUM_OUT_W;
  localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

  // Right wheel weights; sensors beyond the eighth carry no weight.
  function automatic logic signed [COEF_W-1:0] right_coef(input int unsigned idx);
    case (idx)
      0:       return 6'sd16;
      1:       return 6'sd9;
      2:       return 6'sd6;
      3:       return 6'sd3;
      4:       return -6'sd1;
      5:       return -6'sd5;
      6:       return -6'sd6;
      7:       return -6'sd8;
      default: return '0;
    endcase
  endfunction

  // Left wheel weights; sensors beyond the eighth carry no weight.
  function automatic logic signed [COEF_W-1:0] left_coef(input int unsigned idx);
    case (idx)
      0:       return -6'sd12;
      1:       return -6'sd8;
      2:       return -6'sd5;
      3:       return 6'sd6;
      4:       return 6'sd2;
      5:       return 6'sd4;
      6:       return 6'sd5;
      7:       return 6'sd9;
      default: return '0;
    endcase
  endfunction

endpackage

// ===== rtl/bws_lane.sv =====
// One sensor lane: registers the reading and its two weighted products.
module bws_lane #(
  parameter int LANE         = 0,
  parameter int READING_BITS = bws_pkg::READING_BITS_DEF,
  parameter int PROD_W       = READING_BITS + bws_pkg::COEF_W + 1
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic [READING_BITS-1:0]  reading,
  output logic [READING_BITS-1:0]  reading_q,
  output logic signed [PROD_W-1:0] right_prod,
  output logic signed [PROD_W-1:0] left_prod
);

  logic signed [PROD_W-1:0] reading_ext;
  logic signed [PROD_W-1:0] right_w;
  logic signed [PROD_W-1:0] left_w;

  // Widen the reading and the lane's fixed weights before multiplying.
  assign reading_ext = PROD_W'($signed({1'b0, reading}));
  assign right_w     = PROD_W'(bws_pkg::right_coef(LANE));
  assign left_w      = PROD_W'(bws_pkg::left_coef(LANE));

  // Constant-weight products, registered for the merge stage.
  always_ff @(posedge clk) begin
    if (en) begin
      reading_q  <= reading;
      right_prod <= reading_ext * right_w;
      left_prod  <= reading_ext * left_w;
    end
  end

endmodule

// ===== rtl/bws_merge.sv =====
// Merge stage: combines the lane results into wheel sums, peak and total.
module bws_merge #(
  parameter int SENSOR_COUNT = bws_pkg::SENSOR_COUNT_DEF,
  parameter int READING_BITS = bws_pkg::READING_BITS_DEF,
  parameter int PROD_W       = READING_BITS + bws_pkg::COEF_W + 1,
  parameter int SUM_W        = PROD_W + $clog2(SENSOR_COUNT),
  parameter int RSUM_W       = READING_BITS + $clog2(SENSOR_COUNT)
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic [READING_BITS-1:0]  readings    [SENSOR_COUNT],
  input  logic signed [PROD_W-1:0] right_prods [SENSOR_COUNT],
  input  logic signed [PROD_W-1:0] left_prods  [SENSOR_COUNT],
  output logic signed [SUM_W-1:0]  right_sum,
  output logic signed [SUM_W-1:0]  left_sum,
  output logic [READING_BITS-1:0]  peak,
  output logic [RSUM_W-1:0]        total
);

  logic signed [SUM_W-1:0] right_acc;
  logic signed [SUM_W-1:0] left_acc;
  logic [READING_BITS-1:0] peak_acc;
  logic [RSUM_W-1:0]       total_acc;

  // Sum the products and readings and find the largest reading.
  always_comb begin
    right_acc = '0;
    left_acc  = '0;
    peak_acc  = '0;
    total_acc = '0;
    for (int i = 0; i < SENSOR_COUNT; i++) begin
      right_acc = right_acc + SUM_W'(right_prods[i]);
      left_acc  = left_acc + SUM_W'(left_prods[i]);
      total_acc = total_acc + RSUM_W'(readings[i]);
      if (readings[i] > peak_acc) begin
        peak_acc = readings[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      right_sum <= right_acc;
      left_sum  <= left_acc;
      peak      <= peak_acc;
      total     <= total_acc;
    end
  end

endmodule

// ===== rtl/bws_div.sv =====
// Pipelined restoring divider, one quotient bit per stage.
module bws_div #(
  parameter int NUM_W = 29,
  parameter int DEN_W = 19,
  parameter int Q_W   = bws_pkg::LIMIT_W
) (
  input  logic             clk,
  input  logic [Q_W-1:0]   en,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic [Q_W-1:0]   quot
);

  logic [NUM_W-1:0] rem [Q_W];
  logic [DEN_W-1:0] dsr [Q_W];
  logic [Q_W-1:0]   qb  [Q_W];

  // Stage j settles quotient bit Q_W-1-j; the quotient is known to fit Q_W bits.
  for (genvar j = 0; j < Q_W; j++) begin : g_step
    localparam int K = Q_W - 1 - j;
    logic [NUM_W-1:0] rem_in;
    logic [DEN_W-1:0] den_in;
    logic [Q_W-1:0]   q_in;
    logic [NUM_W-1:0] trial;
    logic             fits;
    logic [Q_W-1:0]   q_next;

    if (j == 0) begin : g_first
      assign rem_in = num;
      assign den_in = den;
      assign q_in   = '0;
    end else begin : g_rest
      assign rem_in = rem[j-1];
      assign den_in = dsr[j-1];
      assign q_in   = qb[j-1];
    end

    // Trial subtract of the shifted divisor.
    always_comb begin
      trial     = NUM_W'(den_in) << K;
      fits      = rem_in >= trial;
      q_next    = q_in;
      q_next[K] = fits;
    end

    always_ff @(posedge clk) begin
      if (en[j]) begin
        rem[j] <= fits ? rem_in - trial : rem_in;
        dsr[j] <= den_in;
        qb[j]  <= q_next;
      end
    end
  end

  assign quot = qb[Q_W-1];

endmodule

// ===== rtl/braitenberg_wheel_speed.sv =====
// Pipeline from an accepted frame to its result word: lanes, merge, scale prep, ten divider
// stages, output register. Throughput: one frame per cycle unless the output stalls,
// set by the pipelined divider with one quotient bit per stage.
// Each stage has its own valid bit, so bubbles fill while the result word waits.
// Reset (rst, synchronous, active high) empties the pipeline and sets speed_limit to 400.
module braitenberg_wheel_speed #(
  parameter int SENSOR_COUNT = bws_pkg::SENSOR_COUNT_DEF,
  parameter int READING_BITS = bws_pkg::READING_BITS_DEF
) (
  input  logic clk,
  input  logic rst,
  // Frame input word.
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  // Fields from the lowest bit up: sensor_0 .. sensor_N-1, READING_BITS each, zero fill.
  input  logic [((SENSOR_COUNT*READING_BITS+7)/8)*8-1:0] s_axis_tdata,
  // Result output word.
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  // Fields from the lowest bit up: left_speed, right_speed, peak_reading, reading_sum, zero fill.
  output logic [bws_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  // Fields from the lowest bit up: was_scaled.
  output logic [0:0] m_axis_tuser,
  // Speed limit register write.
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [bws_pkg::LIMIT_W-1:0] cfg_data
);

`include "braitenberg_wheel_speed_assert.svh"

  localparam int LIMIT_W    = bws_pkg::LIMIT_W;
  localparam int SPEED_W    = bws_pkg::SPEED_W;
  localparam int PEAK_W     = bws_pkg::PEAK_W;
  localparam int RSUM_OUT_W = bws_pkg::RSUM_OUT_W;
  localparam int PROD_W     = READING_BITS + bws_pkg::COEF_W + 1;
  localparam int SUM_W      = PROD_W + $clog2(SENSOR_COUNT);
  localparam int RSUM_W     = READING_BITS + $clog2(SENSOR_COUNT);
  localparam int DIVD_W     = SUM_W + LIMIT_W;
  localparam int DIV_STAGES = LIMIT_W;
  localparam int PREP_STAGE = 2;
  localparam int OUT_STAGE  = PREP_STAGE + DIV_STAGES + 1;
  localparam int NSTAGE     = OUT_STAGE + 1;

  // Fields that ride alongside the divider.
  typedef struct packed {
    logic signed [SPEED_W-1:0] left_raw;
    logic signed [SPEED_W-1:0] right_raw;
    logic                      left_neg;
    logic                      right_neg;
    logic                      scaled;
    logic [LIMIT_W-1:0]        lim;
    logic [PEAK_W-1:0]         peak;
    logic [RSUM_OUT_W-1:0]     total;
  } side_t;

  logic [NSTAGE-1:0]  valid;
  logic [NSTAGE-1:0]  adv;
  logic [LIMIT_W-1:0] speed_limit;

  // Stage handshake: a stage loads when it is empty or its word moves on.
  always_comb begin
    adv[NSTAGE-1] = !valid[NSTAGE-1] || m_axis_tready;
    for (int i = NSTAGE - 2; i >= 0; i--) begin
      adv[i] = !valid[i] || adv[i+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      if (adv[0]) begin
        valid[0] <= s_axis_tvalid;
      end
      for (int i = 1; i < NSTAGE; i++) begin
        if (adv[i]) begin
          valid[i] <= valid[i-1];
        end
      end
    end
  end

  assign s_axis_tready = adv[0];

  // Speed limit register.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      speed_limit <= bws_pkg::LIMIT_RESET;
    end else if (cfg_valid) begin
      speed_limit <= cfg_data;
    end
  end

  // Sensor lanes.
  logic [READING_BITS-1:0]  lane_reading [SENSOR_COUNT];
  logic signed [PROD_W-1:0] lane_right   [SENSOR_COUNT];
  logic signed [PROD_W-1:0] lane_left    [SENSOR_COUNT];

  for (genvar g = 0; g < SENSOR_COUNT; g++) begin : g_lane
    bws_lane #(
      .LANE        (g),
      .READING_BITS(READING_BITS),
      .PROD_W      (PROD_W)
    ) u_lane (
      .clk       (clk),
      .en        (adv[0]),
      .reading   (s_axis_tdata[g*READING_BITS +: READING_BITS]),
      .reading_q (lane_reading[g]),
      .right_prod(lane_right[g]),
      .left_prod (lane_left[g])
    );
  end

  // Merge of the lane results.
  logic signed [SUM_W-1:0] right_sum;
  logic signed [SUM_W-1:0] left_sum;
  logic [READING_BITS-1:0] peak_m;
  logic [RSUM_W-1:0]       total_m;

  bws_merge #(
    .SENSOR_COUNT(SENSOR_COUNT),
    .READING_BITS(READING_BITS),
    .PROD_W      (PROD_W),
    .SUM_W       (SUM_W),
    .RSUM_W      (RSUM_W)
  ) u_merge (
    .clk        (clk),
    .en         (adv[1]),
    .readings   (lane_reading),
    .right_prods(lane_right),
    .left_prods (lane_left),
    .right_sum  (right_sum),
    .left_sum   (left_sum),
    .peak       (peak_m),
    .total      (total_m)
  );

  // Scale prep: magnitudes, limit check and the dividends |speed| * limit.
  logic [SUM_W-1:0]  left_mag;
  logic [SUM_W-1:0]  right_mag;
  logic [SUM_W-1:0]  top_mag;
  logic [SUM_W-1:0]  lim_ext;
  logic              over;
  logic [DIVD_W-1:0] num_l;
  logic [DIVD_W-1:0] num_r;
  logic [SUM_W-1:0]  den;
  side_t             side [DIV_STAGES+1];

  always_comb begin
    left_mag  = left_sum[SUM_W-1] ? SUM_W'(-left_sum) : SUM_W'(left_sum);
    right_mag = right_sum[SUM_W-1] ? SUM_W'(-right_sum) : SUM_W'(right_sum);
    top_mag   = (left_mag > right_mag) ? left_mag : right_mag;
    lim_ext   = SUM_W'(speed_limit);
    over      = (left_mag > lim_ext) || (right_mag > lim_ext);
  end

  always_ff @(posedge clk) begin
    if (adv[PREP_STAGE]) begin
      num_l             <= DIVD_W'(left_mag) * DIVD_W'(speed_limit);
      num_r             <= DIVD_W'(right_mag) * DIVD_W'(speed_limit);
      den               <= top_mag;
      side[0].left_raw  <= SPEED_W'(left_sum);
      side[0].right_raw <= SPEED_W'(right_sum);
      side[0].left_neg  <= left_sum[SUM_W-1];
      side[0].right_neg <= right_sum[SUM_W-1];
      side[0].scaled    <= over;
      side[0].lim       <= speed_limit;
      side[0].peak      <= PEAK_W'(peak_m);
      side[0].total     <= RSUM_OUT_W'(total_m);
    end
    // Side fields follow the divider stage by stage.
    for (int j = 1; j <= DIV_STAGES; j++) begin
      if (adv[PREP_STAGE+j]) begin
        side[j] <= side[j-1];
      end
    end
  end

  // One divider lane per wheel, sharing the peak magnitude as divisor.
  logic [LIMIT_W-1:0] quot_l;
  logic [LIMIT_W-1:0] quot_r;

  bws_div #(
    .NUM_W(DIVD_W),
    .DEN_W(SUM_W),
    .Q_W  (LIMIT_W)
  ) u_div_left (
    .clk (clk),
    .en  (adv[PREP_STAGE+1 +: DIV_STAGES]),
    .num (num_l),
    .den (den),
    .quot(quot_l)
  );

  bws_div #(
    .NUM_W(DIVD_W),
    .DEN_W(SUM_W),
    .Q_W  (LIMIT_W)
  ) u_div_right (
    .clk (clk),
    .en  (adv[PREP_STAGE+1 +: DIV_STAGES]),
    .num (num_r),
    .den (den),
    .quot(quot_r)
  );

  // Output register: restore signs of scaled speeds, else pass them through.
  side_t                     side_o;
  logic signed [SPEED_W-1:0] left_o;
  logic signed [SPEED_W-1:0] right_o;
  logic signed [SPEED_W-1:0] left_q;
  logic signed [SPEED_W-1:0] right_q;
  logic [PEAK_W-1:0]         peak_q;
  logic [RSUM_OUT_W-1:0]     total_q;
  logic                      scaled_q;
  logic [LIMIT_W-1:0]        lim_q;

  always_comb begin
    side_o = side[DIV_STAGES];
    if (side_o.scaled) begin
      left_o  = side_o.left_neg ? -SPEED_W'(quot_l) : SPEED_W'(quot_l);
      right_o = side_o.right_neg ? -SPEED_W'(quot_r) : SPEED_W'(quot_r);
    end else begin
      left_o  = side_o.left_raw;
      right_o = side_o.right_raw;
    end
  end

  always_ff @(posedge clk) begin
    if (adv[OUT_STAGE]) begin
      left_q   <= left_o;
      right_q  <= right_o;
      peak_q   <= side_o.peak;
      total_q  <= side_o.total;
      scaled_q <= side_o.scaled;
      lim_q    <= side_o.lim;
    end
  end

  assign m_axis_tvalid = valid[OUT_STAGE];
  assign m_axis_tdata  = {(bws_pkg::OUT_DATA_W - bws_pkg::OUT_FIELDS_W)'(0),
                          total_q, peak_q, right_q, left_q};
  assign m_axis_tuser  = scaled_q;

  // Speed magnitudes of the result word, for checking against its limit.
  logic [SPEED_W-1:0] lmag;
  logic [SPEED_W-1:0] rmag;
  logic               speeds_ok;
  logic               limit_hit;

  assign lmag      = left_q[SPEED_W-1] ? SPEED_W'(-left_q) : SPEED_W'(left_q);
  assign rmag      = right_q[SPEED_W-1] ? SPEED_W'(-right_q) : SPEED_W'(right_q);
  assign speeds_ok = (lmag <= lim_q) && (rmag <= lim_q);
  assign limit_hit = (lmag == lim_q) || (rmag == lim_q);

  `BWS_ASSERT_IMPL(a_within_limit, m_axis_tvalid, speeds_ok, "speed over limit")
  `BWS_ASSERT_IMPL(a_scaled_hits, m_axis_tvalid && scaled_q, limit_hit, "scale miss")
  `BWS_ASSERT_IMPL(a_reset_empty, $past(rst), !m_axis_tvalid, "result word right after reset")
  `BWS_ASSERT_NEXT(a_accept_loads, s_axis_tvalid && s_axis_tready, valid[0], "accepted frame lost")

endmodule

// ===== tb/wheel_speed_checker.sv =====
`timescale 1ns / 1ps
// Checker for the wheel speed block: predicts every result word from the frames and compares.
module wheel_speed_checker #(
  parameter int FRAME_W = 96,
  parameter int SENSORS = 8,
  parameter int RBITS   = 12
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_axis_tvalid,
  input  logic                              s_axis_tready,
  input  logic [FRAME_W-1:0]                s_axis_tdata,
  input  logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  input  logic [bws_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
  input  logic [0:0]                        m_axis_tuser,
  input  logic                              cfg_valid,
  input  logic                              cfg_ready,
  input  logic [bws_pkg::LIMIT_W-1:0]       cfg_data,
  output int                                outstanding,
  output int                                mismatch_count
);

  typedef struct packed {
    logic signed [bws_pkg::SPEED_W-1:0] left;
    logic signed [bws_pkg::SPEED_W-1:0] right;
    logic [bws_pkg::PEAK_W-1:0]         peak;
    logic [bws_pkg::RSUM_OUT_W-1:0]     reading_sum;
    logic                               scaled;
  } wheel_result_t;

  // Steering weights per sensor, right wheel and left wheel.
  int right_weight [8] = '{16, 9, 6, 3, -1, -5, -6, -8};
  int left_weight  [8] = '{-12, -8, -5, 6, 2, 4, 5, 9};

  wheel_result_t pending_speeds [$];
  logic [bws_pkg::LIMIT_W-1:0] limit_now;

  // Weighted sums, peak and total of one frame, then the ratio-keeping scale to the limit.
  function automatic wheel_result_t predict_wheel_speeds(input logic [FRAME_W-1:0] frame,
                                                         input logic [bws_pkg::LIMIT_W-1:0] lim);
    wheel_result_t res;
    longint right_acc, left_acc, peak, total, reading, mag_l, mag_r, peak_mag, lim_l;
    int i;
    right_acc = 0;
    left_acc  = 0;
    peak      = 0;
    total     = 0;
    for (i = 0; i < SENSORS; i++) begin
      reading = frame[i*RBITS +: RBITS];
      total += reading;
      if (reading > peak) peak = reading;
      right_acc += right_weight[i] * reading;
      left_acc  += left_weight[i] * reading;
    end
    lim_l = lim;
    mag_l = (left_acc < 0) ? -left_acc : left_acc;
    mag_r = (right_acc < 0) ? -right_acc : right_acc;
    res.scaled = 1'b0;
    if (mag_l > lim_l || mag_r > lim_l) begin
      // Signed division truncates toward zero.
      peak_mag  = (mag_l > mag_r) ? mag_l : mag_r;
      left_acc  = left_acc * lim_l / peak_mag;
      right_acc = right_acc * lim_l / peak_mag;
      res.scaled = 1'b1;
    end
    res.left        = left_acc[bws_pkg::SPEED_W-1:0];
    res.right       = right_acc[bws_pkg::SPEED_W-1:0];
    res.peak        = peak[bws_pkg::PEAK_W-1:0];
    res.reading_sum = total[bws_pkg::RSUM_OUT_W-1:0];
    return res;
  endfunction

  task automatic report(input string what);
    mismatch_count++;
    $display("%0t ns: MISMATCH %s", $time, what);
  endtask

  // Watch all three channels at the rising edge; results are matched in order.
  always @(posedge clk) begin
    wheel_result_t want, got;
    if (rst) begin
      pending_speeds.delete();
      limit_now = bws_pkg::LIMIT_RESET;
      outstanding <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.left        = m_axis_tdata[bws_pkg::SPEED_W-1:0];
        got.right       = m_axis_tdata[bws_pkg::SPEED_W +: bws_pkg::SPEED_W];
        got.peak        = m_axis_tdata[2*bws_pkg::SPEED_W +: bws_pkg::PEAK_W];
        got.reading_sum = m_axis_tdata[2*bws_pkg::SPEED_W+bws_pkg::PEAK_W +: bws_pkg::RSUM_OUT_W];
        got.scaled      = m_axis_tuser[0];
        if (pending_speeds.size() == 0) begin
          report("result word with no frame waiting");
        end else begin
          want = pending_speeds.pop_front();
          if (got !== want)
            report($sformatf({"got/want left %0d/%0d right %0d/%0d peak %0d/%0d ",
                              "sum %0d/%0d scaled %b/%b"},
                             got.left, want.left, got.right, want.right, got.peak, want.peak,
                             got.reading_sum, want.reading_sum, got.scaled, want.scaled));
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        pending_speeds.push_back(predict_wheel_speeds(s_axis_tdata, limit_now));
      if (cfg_valid && cfg_ready) limit_now = cfg_data;
      outstanding <= pending_speeds.size();
    end
  end

endmodule

// ===== tb/tb_braitenberg_wheel_speed.sv =====
`timescale 1ns / 1ps
// Testbench top for the wheel speed block: frame stimulus, receiver stalls and the verdict.
module tb_braitenberg_wheel_speed;

  localparam int SENSORS       = 8;
  localparam int RBITS         = 12;
  localparam int FRAME_W       = ((SENSORS*RBITS+7)/8)*8;
  localparam int HOLD_CYCLES   = 300;
  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_FRAMES  = 200;
  localparam int TAIL_CYCLES   = 40;

  typedef enum int {RX_ALWAYS, RX_MOSTLY, RX_RARELY, RX_PERIODIC} rx_mode_t;
  typedef enum int {RD_FULL, RD_SMALL, RD_EXTREME, RD_ONE_HOT} reading_mode_t;

  logic                           clk;
  logic                           rst;
  logic                           s_axis_tvalid;
  logic                           s_axis_tready;
  logic [FRAME_W-1:0]             s_axis_tdata;
  logic                           m_axis_tvalid;
  logic                           m_axis_tready = 1'b0;
  logic [bws_pkg::OUT_DATA_W-1:0] m_axis_tdata;
  logic [0:0]                     m_axis_tuser;
  logic                           cfg_valid;
  logic                           cfg_ready;
  logic [bws_pkg::LIMIT_W-1:0]    cfg_data;
  int                             outstanding;
  int                             mismatch_count;

  // Receiver control: a new hold request starts a long stall.
  rx_mode_t rx_mode   = RX_ALWAYS;
  int       hold_seq  = 0;
  int       hold_seen = 0;
  int       hold_left = 0;
  int       rx_tick   = 0;

  braitenberg_wheel_speed dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data)
  );

  wheel_speed_checker #(.FRAME_W(FRAME_W), .SENSORS(SENSORS), .RBITS(RBITS)) speed_check (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .outstanding   (outstanding),
    .mismatch_count(mismatch_count)
  );

  // 12 ns clock.
  initial clk = 1'b0;
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Run limit, far above the slowest correct run.
  initial begin
    #5_000_000;
    $display("Verification failed");
    $finish;
  end

  // Result receiver: long holds on request, otherwise the current stall pattern.
  always @(negedge clk) begin
    rx_tick <= rx_tick + 1;
    if (hold_seq != hold_seen) begin
      hold_seen     <= hold_seq;
      hold_left     <= HOLD_CYCLES;
      m_axis_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left     <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      case (rx_mode)
        RX_ALWAYS: m_axis_tready <= 1'b1;
        RX_MOSTLY: m_axis_tready <= ($urandom_range(0, 3) != 0);
        RX_RARELY: m_axis_tready <= ($urandom_range(0, 3) == 0);
        default:   m_axis_tready <= ((rx_tick % 7) < 4);
      endcase
    end
  end

  function automatic logic [FRAME_W-1:0] uniform_frame(input int value);
    logic [FRAME_W-1:0] frame;
    int i;
    frame = '0;
    for (i = 0; i < SENSORS; i++) frame[i*RBITS +: RBITS] = RBITS'(value);
    return frame;
  endfunction

  function automatic logic [FRAME_W-1:0] single_frame(input int idx, input int value);
    logic [FRAME_W-1:0] frame;
    frame = '0;
    frame[idx*RBITS +: RBITS] = RBITS'(value);
    return frame;
  endfunction

  // Mix of full-range, small (mostly unscaled), extreme and one-hot frames.
  function automatic logic [FRAME_W-1:0] random_frame();
    logic [FRAME_W-1:0] frame;
    reading_mode_t mode;
    int hot;
    int i;
    frame = '0;
    mode  = reading_mode_t'($urandom_range(0, 3));
    hot   = $urandom_range(0, SENSORS-1);
    for (i = 0; i < SENSORS; i++) begin
      case (mode)
        RD_SMALL:   frame[i*RBITS +: RBITS] = RBITS'($urandom_range(0, 31));
        RD_EXTREME: frame[i*RBITS +: RBITS] = $urandom_range(0, 1) ? '1 : '0;
        RD_ONE_HOT: if (i == hot) frame[i*RBITS +: RBITS] = RBITS'($urandom);
        default:    frame[i*RBITS +: RBITS] = RBITS'($urandom);
      endcase
    end
    return frame;
  endfunction

  // Offer one frame word and hold it until it is taken.
  task automatic send_frame(input logic [FRAME_W-1:0] frame);
    @(negedge clk);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= frame;
    do @(posedge clk); while (!s_axis_tready);
  endtask

  // Idle the sender for a number of cycles, with junk on the data lines.
  task automatic pause_sender(input int cycles);
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= {$urandom, $urandom, $urandom};
    repeat (cycles - 1) @(negedge clk);
  endtask

  // Stop sending until every predicted result has come back.
  task automatic wait_drained();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
  endtask

  // The limit is only changed while the pipeline is empty.
  task automatic write_limit(input logic [bws_pkg::LIMIT_W-1:0] value);
    wait_drained();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    cfg_data  <= bws_pkg::LIMIT_W'($urandom);
  endtask

  initial begin
    int i, phase, sent, burst, k;
    logic [bws_pkg::LIMIT_W-1:0] lim;
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    cfg_valid     = 1'b0;
    cfg_data      = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed frames under the reset limit: extremes, each weight alone, the limit edge.
    send_frame(uniform_frame(0));
    send_frame(uniform_frame(4095));
    for (i = 0; i < SENSORS; i++) send_frame(single_frame(i, 4095));
    send_frame(uniform_frame(12'hAAA));
    send_frame(uniform_frame(12'h555));
    send_frame(uniform_frame(1));
    send_frame(single_frame(0, 25));
    send_frame(single_frame(0, 26));

    // Zero limit: zero sums pass, any nonzero speed collapses to zero.
    write_limit(0);
    rx_mode = RX_PERIODIC;
    send_frame(uniform_frame(0));
    send_frame(uniform_frame(1));

    // Largest register value, then the smallest nonzero one.
    write_limit(1023);
    send_frame(uniform_frame(4095));
    send_frame(single_frame(0, 4095));
    write_limit(1);
    send_frame(uniform_frame(1));

    // Random phases, each with its own limit and receiver pattern.
    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      case (phase)
        0:       lim = 1000;
        1:       lim = bws_pkg::LIMIT_W'($urandom_range(50, 600));
        2:       lim = 0;
        3:       lim = 1023;
        4:       lim = 1;
        5:       lim = bws_pkg::LIMIT_W'($urandom);
        6:       lim = bws_pkg::LIMIT_W'($urandom_range(1, 20));
        default: lim = 400;
      endcase
      write_limit(lim);
      @(posedge clk);
      rx_mode = rx_mode_t'($urandom_range(0, 3));
      // In two phases the receiver stalls long while frames keep coming.
      if (phase == 1 || phase == 5) hold_seq++;
      sent = 0;
      while (sent < PHASE_FRAMES) begin
        burst = $urandom_range(1, 24);
        for (k = 0; k < burst && sent < PHASE_FRAMES; k++) begin
          send_frame(random_frame());
          sent++;
        end
        if (phase != 1 && phase != 5 && $urandom_range(0, 3) != 0)
          pause_sender($urandom_range(1, 10));
      end
    end

    // Drain, then watch for stray words before the verdict.
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/bws_pkg.sv
rtl/bws_lane.sv
rtl/bws_merge.sv
rtl/bws_div.sv
rtl/braitenberg_wheel_speed.sv
tb/wheel_speed_checker.sv
tb/tb_braitenberg_wheel_speed.sv
